/* rtl/rbf_pkg.sv */
// ----------------------------------------------------------------------------
// rbf_pkg
// shared types, codes and reset values for the rectangle blitter
// ----------------------------------------------------------------------------
package rbf_pkg;

  // default sizes
  localparam int unsigned MAX_DIM_DEF      = 1024;
  localparam int unsigned PALETTE_SIZE_DEF = 256;

  // field widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned ADDR_W     = 20;

  // register reset values
  localparam logic [DIM_W-1:0] DST_WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0] DST_HEIGHT_RST = 11'd1024;
  localparam logic [CNT_W-1:0] PAL_COUNT_RST  = 9'd256;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECT_W     = 3'd0,
    CFG_RECT_H     = 3'd1,
    CFG_DST_X      = 3'd2,
    CFG_DST_Y      = 3'd3,
    CFG_DST_WIDTH  = 3'd4,
    CFG_DST_HEIGHT = 3'd5,
    CFG_MODE       = 3'd6,
    CFG_PAL_COUNT  = 3'd7
  } cfg_idx_e;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_PIXEL    = 2'd0,
    FUNC_LOAD_SRC = 2'd1,
    FUNC_LOAD_DST = 2'd2
  } func_e;

  // blit modes, the unused code behaves as a direct copy
  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_REMAP  = 2'd1,
    MODE_FILL   = 2'd2
  } mode_e;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_ADDR     = 7'b0000010,
    ST_CHECK    = 7'b0000100,
    ST_SRCH_RD  = 7'b0001000,
    ST_SRCH_CMP = 7'b0010000,
    ST_RESULT   = 7'b0100000,
    ST_SRCH_END = 7'b1000000
  } state_e;

endpackage

/* rtl/rect_blit_fill_palette_remap_unit.sv */
// ----------------------------------------------------------------------------
// rect_blit_fill_palette_remap_unit
// rectangle blitter: direct copy, palette index remap and palette colour fill
// ----------------------------------------------------------------------------
// sequence: a pixel item is taken in idle and its address is formed; direct copy and
//   clipped pixels then go to the result, a remap first checks the same destination index,
//   and the palette search reads, compares and steps one entry at a time with the single
//   shared comparator; no new item (pixel or palette load) is taken until the result is
//   loaded into the output register, and a stalled result holds the sequencer
// reset: async active low, counters, sequencer and config registers; no palette reset

module rect_blit_fill_palette_remap_unit
  import rbf_pkg::*;
#(
  parameter int unsigned MAX_DIM      = MAX_DIM_DEF,
  parameter int unsigned PALETTE_SIZE = PALETTE_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  // input item channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            func_i,
  input  logic [PIX_W-1:0]      pixel_value_i,
  input  logic [7:0]            palette_index_i,
  input  logic [PIX_W-1:0]      palette_color_i,

  // result item channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  write_enable_o,
  output logic [ADDR_W-1:0]     write_address_o,
  output logic [PIX_W-1:0]      write_data_o,
  output logic                  color_found_o,
  output logic                  rect_done_o
);

  localparam int unsigned IW = $clog2(PALETTE_SIZE);

  // 8-bit value modulo the palette size, by restoring subtraction
  function automatic logic [IW-1:0] pal_mod(input logic [7:0] v);
    logic [15:0] r;
    r = {8'd0, v};
    for (int s = 7; s >= 0; s--) begin
      if (r >= 16'(PALETTE_SIZE << s)) begin
        r = r - 16'(PALETTE_SIZE << s);
      end
    end
    return r[IW-1:0];
  endfunction

  // configuration registers
  logic [DIM_W-1:0] rect_w_q, rect_h_q, dst_width_q, dst_height_q;
  logic [POS_W-1:0] dst_x_q, dst_y_q;
  logic [1:0]       mode_cfg_q;
  logic [CNT_W-1:0] pal_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_w_q     <= '0;
      rect_h_q     <= '0;
      dst_x_q      <= '0;
      dst_y_q      <= '0;
      dst_width_q  <= DST_WIDTH_RST;
      dst_height_q <= DST_HEIGHT_RST;
      mode_cfg_q   <= MODE_DIRECT;
      pal_count_q  <= PAL_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RECT_W:     rect_w_q     <= cfg_data_i;
        CFG_RECT_H:     rect_h_q     <= cfg_data_i;
        CFG_DST_X:      dst_x_q      <= cfg_data_i[POS_W-1:0];
        CFG_DST_Y:      dst_y_q      <= cfg_data_i[POS_W-1:0];
        CFG_DST_WIDTH:  dst_width_q  <= cfg_data_i;
        CFG_DST_HEIGHT: dst_height_q <= cfg_data_i;
        CFG_MODE:       mode_cfg_q   <= cfg_data_i[1:0];
        CFG_PAL_COUNT:  pal_count_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // surface size clipped at the largest dimension
  logic [DIM_W-1:0] surf_w, surf_h;
  assign surf_w = (32'(dst_width_q) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dst_width_q;
  assign surf_h = (32'(dst_height_q) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dst_height_q;

  // number of destination entries searched, saturated at the palette size
  logic [CNT_W-1:0] search_n;
  assign search_n = (32'(pal_count_q) > 32'(PALETTE_SIZE)) ? CNT_W'(PALETTE_SIZE)
                                                            : pal_count_q;

  // handshakes
  state_e state_q, state_d;
  logic   in_acc, pix_acc;
  logic   out_valid_q;
  logic   out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_acc    = in_acc && (func_e'(func_i) == FUNC_PIXEL);
  assign out_load   = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);

  // raster position of the incoming pixel
  logic [DIM_W-1:0] col_q, row_q;
  logic [DIM_W:0]   pos_x, pos_y;
  logic             rect_empty, pix_inside;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             col_wrap, row_wrap;

  assign pos_x      = (DIM_W+1)'(dst_x_q) + (DIM_W+1)'(col_q);
  assign pos_y      = (DIM_W+1)'(dst_y_q) + (DIM_W+1)'(row_q);
  assign rect_empty = (rect_w_q == '0) || (rect_h_q == '0);
  assign pix_inside = !rect_empty && (pos_x < (DIM_W+1)'(surf_w))
                                  && (pos_y < (DIM_W+1)'(surf_h));
  assign col_inc    = col_q + 1'b1;
  assign row_inc    = row_q + 1'b1;
  assign col_wrap   = (col_inc >= rect_w_q) || (col_inc == '0);
  assign row_wrap   = (row_inc >= rect_h_q) || (row_inc == '0);

  // counters advance as each pixel item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_acc) begin
      if (rect_empty) begin
        col_q <= '0;
        row_q <= '0;
      end else if (!col_wrap) begin
        col_q <= col_inc;
      end else begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_inc;
      end
    end
  end

  // palette memories, one write and one registered read each
  logic [PIX_W-1:0] src_mem [PALETTE_SIZE];
  logic [PIX_W-1:0] dst_mem [PALETTE_SIZE];
  logic [PIX_W-1:0] src_rd_q, dst_rd_q;
  logic [IW-1:0]    wr_idx, idx_q, k_q, dst_raddr;

  assign wr_idx    = pal_mod(palette_index_i);
  assign dst_raddr = (state_q == ST_SRCH_RD) ? k_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && (func_e'(func_i) == FUNC_LOAD_SRC)) begin
      src_mem[wr_idx] <= palette_color_i;
    end
    src_rd_q <= src_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (func_e'(func_i) == FUNC_LOAD_DST)) begin
      dst_mem[wr_idx] <= palette_color_i;
    end
    dst_rd_q <= dst_mem[dst_raddr];
  end

  // the one shared colour comparator
  logic [PIX_W-1:0] colour_q, cmp_rhs;
  logic             cmp_eq, srch_last;

  assign cmp_rhs   = (state_q == ST_CHECK) ? src_rd_q : colour_q;
  assign cmp_eq    = (dst_rd_q == cmp_rhs);
  assign srch_last = (CNT_W'(k_q) == (search_n - 1'b1));

  // per pixel working registers
  logic [1:0]            mode_q;
  logic [PIX_W-1:0]      pv_q;
  logic [DIM_W-1:0]      x_q, y_q, w_q;
  logic [2*DIM_W-1:0]    prod_q;
  logic                  inside_q, done_q;
  logic [PIX_W-1:0]      data_q;
  logic                  found_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pix_acc) state_d = ST_ADDR;
      end
      ST_ADDR: begin
        if (!inside_q) begin
          state_d = ST_RESULT;
        end else begin
          case (mode_e'(mode_q))
            MODE_REMAP: state_d = ST_CHECK;
            MODE_FILL:  state_d = (search_n == '0) ? ST_RESULT : ST_SRCH_RD;
            default:    state_d = ST_RESULT;
          endcase
        end
      end
      ST_CHECK: begin
        if (cmp_eq || (search_n == '0)) state_d = ST_RESULT;
        else                           state_d = ST_SRCH_RD;
      end
      ST_SRCH_RD:  state_d = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (cmp_eq || srch_last) state_d = ST_RESULT;
        else                     state_d = ST_SRCH_END;
      end
      // step to the next entry before the next read
      ST_SRCH_END: state_d = ST_SRCH_RD;
      ST_RESULT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (pix_acc) begin
          mode_q   <= mode_cfg_q;
          pv_q     <= pixel_value_i;
          colour_q <= pixel_value_i;
          idx_q    <= pal_mod(pixel_value_i[7:0]);
          x_q      <= pos_x[DIM_W-1:0];
          y_q      <= pos_y[DIM_W-1:0];
          w_q      <= surf_w;
          inside_q <= pix_inside;
          done_q   <= rect_empty || (col_wrap && row_wrap);
        end
      end
      ST_ADDR: begin
        prod_q  <= y_q * w_q;
        k_q     <= '0;
        found_q <= 1'b0;
        // direct copy passes the value, clipped and palette misses give zero
        if (inside_q && (mode_e'(mode_q) != MODE_REMAP) && (mode_e'(mode_q) != MODE_FILL)) begin
          data_q <= pv_q;
        end else begin
          data_q <= '0;
        end
      end
      ST_CHECK: begin
        colour_q <= src_rd_q;
        if (cmp_eq) begin
          found_q <= 1'b1;
          data_q  <= PIX_W'(idx_q);
        end
      end
      ST_SRCH_CMP: begin
        if (cmp_eq) begin
          found_q <= 1'b1;
          data_q  <= PIX_W'(k_q);
        end
      end
      ST_SRCH_END: k_q <= k_q + 1'b1;
      default: ;
    endcase
  end

  // output register, parts the result side from the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      write_enable_o  <= inside_q;
      write_address_o <= inside_q ? ADDR_W'(prod_q + (2*DIM_W)'(x_q)) : '0;
      write_data_o    <= data_q;
      color_found_o   <= found_q;
      rect_done_o     <= done_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
